@@ sv/tsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared constants and types of the 2-SAT component checker.
// ----------------------------------------------------------------------------
package tsc_pkg;

    // default sizing
    localparam int DEF_MAX_VARS    = 128;
    localparam int DEF_MAX_CLAUSES = 1024;

    // item function codes
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD1,
        S_ADD2,
        S_SCAN,
        S_ROOT,
        S_EDGE,
        S_EDGE_W,
        S_EDGE_U,
        S_SCC_WR,
        S_POP,
        S_POP_LD,
        S_CHK_A,
        S_CHK_B,
        S_CHK_C,
        S_DONE
    } t_state;

endpackage

@@ sv/tsc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/two_sat_scc_checker.sv @@
`timescale 1ns / 1ps
// Add-clause transfer: head read, then one edge write per implication.
// Evaluate transfer: a scan over the nodes, a root opened per unvisited node, each edge
// followed, nodes popped into components, then a check per variable.
// One transfer is worked at a time; each memory has one write port and one read port.
// Synchronous active-low reset clears head and visit valid bits at once, no sweep.
// ----------------------------------------------------------------------------
// two_sat_scc_checker
// 2-SAT satisfiability checker: clause edges kept in linked lists in memory,
// evaluation by an iterative Tarjan component search with stacks in memory.
// ----------------------------------------------------------------------------
module two_sat_scc_checker #(
    parameter int MAX_VARS    = tsc_pkg::DEF_MAX_VARS,
    parameter int MAX_CLAUSES = tsc_pkg::DEF_MAX_CLAUSES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    // input item channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_func,
    input  logic [7:0] i_var_a,
    input  logic       i_pol_a,
    input  logic [7:0] i_var_b,
    input  logic       i_pol_b,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_satisfiable,
    output logic       o_clause_error
);
    import tsc_pkg::*;

    localparam int NODES = 2 * MAX_VARS;
    localparam int EDGES = 2 * MAX_CLAUSES;
    localparam int NW    = $clog2(NODES);
    localparam int EAW   = $clog2(EDGES);
    localparam int EW    = $clog2(EDGES + 1);
    localparam int CW    = NW + 1;
    localparam int NDW   = 2 * CW + 1;
    localparam int WKW   = NW + EW + 2 * CW;
    localparam int EDW   = EW + NW;
    localparam logic [EW:0]  EDGES_L = EDGES[EW:0];
    localparam logic [15:0]  MAXV_L  = MAX_VARS[15:0];
    localparam logic [CW:0]  NODES_L = NODES[CW:0];

    t_state r_state, n_state;

    logic [7:0]    r_var_count;
    logic          r_err;
    logic [EW-1:0] r_total;
    logic [NW-1:0] r_f1, r_f2, r_d1, r_d2;
    logic          r_hv, r_fwd;
    logic [NODES-1:0] r_head_vld, r_node_vld;
    logic [NW:0]   r_i;
    logic [NW-1:0] r_v, r_w;
    logic [EW-1:0] r_e;
    logic [CW-1:0] r_low, r_vis, r_cnt, r_comp, r_ca;
    logic [NW:0]   r_ns, r_wd;
    logic          r_wvld, r_sat;
    logic          r_ovld, r_osat, r_oerr;

    // memory ports
    logic           head_we;
    logic [NW-1:0]  head_waddr, head_raddr;
    logic [EW-1:0]  head_wdata, head_rdata;
    logic           edge_we;
    logic [EAW-1:0] edge_waddr, edge_raddr;
    logic [EDW-1:0] edge_wdata, edge_rdata;
    logic           node_we;
    logic [NW-1:0]  node_waddr, node_raddr;
    logic [NDW-1:0] node_wdata, node_rdata;
    logic           ns_we;
    logic [NW-1:0]  ns_waddr, ns_raddr;
    logic [NW-1:0]  ns_wdata, ns_rdata;
    logic           wk_we;
    logic [NW-1:0]  wk_waddr, wk_raddr;
    logic [WKW-1:0] wk_wdata, wk_rdata;

    // effective variable count and literal node numbers
    logic [15:0]   vc16, n16, va16, vb16, two_n16;
    logic [15:0]   fa16, ta16, fb16, tb16, sum16;
    logic [NW-1:0] n_lo;
    logic [NW:0]   two_n;
    logic          bad, accept;
    logic [EW:0]   total2;

    assign vc16    = {8'd0, r_var_count};
    assign n16     = (vc16 == 16'd0) ? 16'd1 : ((vc16 > MAXV_L) ? MAXV_L : vc16);
    assign two_n16 = n16 << 1;
    assign two_n   = two_n16[NW:0];
    assign n_lo    = n16[NW-1:0];
    assign va16    = {8'd0, i_var_a};
    assign vb16    = {8'd0, i_var_b};
    assign fa16    = (i_pol_a ? 16'd0 : n16) + va16 - 16'd1;
    assign ta16    = (i_pol_a ? n16 : 16'd0) + va16 - 16'd1;
    assign fb16    = (i_pol_b ? 16'd0 : n16) + vb16 - 16'd1;
    assign tb16    = (i_pol_b ? n16 : 16'd0) + vb16 - 16'd1;
    assign total2  = {1'b0, r_total} + {{(EW-1){1'b0}}, 2'd2};
    assign bad     = (va16 == 16'd0) || (va16 > n16) || (vb16 == 16'd0) || (vb16 > n16)
                     || (total2 > EDGES_L);
    assign sum16   = {{(15-NW){1'b0}}, r_i} + n16;

    assign o_cfg_ready    = 1'b1;
    assign o_stall        = (r_state != S_IDLE) || (r_ovld && i_func == FUNC_EVAL);
    assign accept         = i_valid && !o_stall;
    assign o_valid        = r_ovld;
    assign o_satisfiable  = r_osat;
    assign o_clause_error = r_oerr;

    // decoded read data
    logic [EW-1:0] head_val, e_link;
    logic [NW-1:0] e_dest, open_x, pop_node;
    logic [CW-1:0] cnt1, nd_vis, nd_comp, pop_low, pop_vis;
    logic [EW-1:0] pop_edge;
    logic          nd_done;

    assign head_val = r_hv ? head_rdata : '0;
    assign e_link   = edge_rdata[EDW-1:NW];
    assign e_dest   = edge_rdata[NW-1:0];
    assign nd_vis   = node_rdata[NDW-1:CW+1];
    assign nd_done  = node_rdata[CW];
    assign nd_comp  = node_rdata[CW-1:0];
    assign {pop_node, pop_edge, pop_low, pop_vis} = wk_rdata;
    assign cnt1     = r_cnt + 1'b1;
    assign open_x   = (r_state == S_ROOT) ? r_v : r_w;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory port control
    always_comb begin
        n_state    = r_state;
        head_we    = 1'b0;
        head_waddr = r_f1;
        head_wdata = '0;
        head_raddr = fa16[NW-1:0];
        edge_we    = 1'b0;
        edge_waddr = r_total[EAW-1:0];
        edge_wdata = '0;
        edge_raddr = '0;
        node_we    = 1'b0;
        node_waddr = open_x;
        node_wdata = {cnt1, 1'b0, {CW{1'b0}}};
        node_raddr = r_i[NW-1:0];
        ns_we      = 1'b0;
        ns_waddr   = r_ns[NW-1:0];
        ns_wdata   = open_x;
        ns_raddr   = '0;
        wk_we      = 1'b0;
        wk_waddr   = r_wd[NW-1:0];
        wk_wdata   = {r_v, r_e, r_low, r_vis};
        wk_raddr   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_EVAL) begin
                        n_state = S_SCAN;
                    end else if (!bad) begin
                        n_state = S_ADD1;
                    end
                end
            end
            S_ADD1: begin
                edge_we    = 1'b1;
                edge_wdata = {head_val, r_d1};
                head_we    = 1'b1;
                head_waddr = r_f1;
                head_wdata = r_total + 1'b1;
                head_raddr = r_f2;
                n_state    = S_ADD2;
            end
            S_ADD2: begin
                edge_we    = 1'b1;
                edge_wdata = {(r_fwd ? r_total : head_val), r_d2};
                head_we    = 1'b1;
                head_waddr = r_f2;
                head_wdata = r_total + 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                head_raddr = r_i[NW-1:0];
                if (r_i == two_n) begin
                    n_state = S_CHK_A;
                end else if (!r_node_vld[r_i[NW-1:0]]) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                node_we = 1'b1;
                ns_we   = 1'b1;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                edge_raddr = r_e[EAW-1:0] - 1'b1;
                ns_raddr   = r_ns[NW-1:0] - 1'b1;
                if (r_e != '0) begin
                    n_state = S_EDGE_W;
                end else if (r_low == r_vis) begin
                    n_state = S_SCC_WR;
                end else begin
                    n_state = S_POP;
                end
            end
            S_EDGE_W: begin
                node_raddr = e_dest;
                head_raddr = e_dest;
                n_state    = S_EDGE_U;
            end
            S_EDGE_U: begin
                if (!r_wvld) begin
                    node_we = 1'b1;
                    ns_we   = 1'b1;
                    wk_we   = 1'b1;
                end
                n_state = S_EDGE;
            end
            S_SCC_WR: begin
                node_we    = 1'b1;
                node_waddr = ns_rdata;
                node_wdata = {{CW{1'b0}}, 1'b1, r_comp};
                ns_raddr   = r_ns[NW-1:0] - 2'd2;
                if (ns_rdata == r_v) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                wk_raddr = r_wd[NW-1:0] - 1'b1;
                n_state  = (r_wd != '0) ? S_POP_LD : S_SCAN;
            end
            S_POP_LD: begin
                n_state = S_EDGE;
            end
            S_CHK_A: begin
                node_raddr = r_i[NW-1:0];
                n_state    = S_CHK_B;
            end
            S_CHK_B: begin
                node_raddr = sum16[NW-1:0];
                n_state    = S_CHK_C;
            end
            S_CHK_C: begin
                n_state = (r_i + 1'b1 == {1'b0, n_lo}) ? S_DONE : S_CHK_A;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_count <= 8'd1;
            r_err       <= 1'b0;
            r_total     <= '0;
            r_head_vld  <= '0;
            r_node_vld  <= '0;
            r_cnt       <= '0;
            r_comp      <= '0;
            r_ns        <= '0;
            r_wd        <= '0;
            r_ovld      <= 1'b0;
        end else begin
            // head valid for whatever was read this cycle
            r_hv <= r_head_vld[head_raddr];
            if (i_cfg_valid && o_cfg_ready) begin
                r_var_count <= i_cfg_data;
            end
            if (r_ovld && !i_stall) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_f1  <= fa16[NW-1:0];
                    r_d1  <= tb16[NW-1:0];
                    r_f2  <= fb16[NW-1:0];
                    r_d2  <= ta16[NW-1:0];
                    r_i   <= '0;
                    r_sat <= 1'b1;
                    if (accept && i_func == FUNC_ADD && bad) begin
                        r_err <= 1'b1;
                    end
                end
                S_ADD1: begin
                    r_head_vld[r_f1] <= 1'b1;
                    r_fwd            <= (r_f2 == r_f1);
                    r_total          <= r_total + 1'b1;
                end
                S_ADD2: begin
                    r_head_vld[r_f2] <= 1'b1;
                    r_total          <= r_total + 1'b1;
                end
                S_SCAN: begin
                    if (r_i == two_n) begin
                        r_i <= '0;
                    end else if (r_node_vld[r_i[NW-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_v <= r_i[NW-1:0];
                    end
                end
                S_ROOT: begin
                    r_node_vld[open_x] <= 1'b1;
                    r_cnt <= cnt1;
                    r_ns  <= r_ns + 1'b1;
                    r_v   <= open_x;
                    r_e   <= head_val;
                    r_low <= cnt1;
                    r_vis <= cnt1;
                end
                S_EDGE: begin
                    if (r_e == '0 && r_low == r_vis) begin
                        r_comp <= r_comp + 1'b1;
                    end
                end
                S_EDGE_W: begin
                    r_e    <= e_link;
                    r_w    <= e_dest;
                    r_wvld <= r_node_vld[e_dest];
                end
                S_EDGE_U: begin
                    if (!r_wvld) begin
                        // open the child, parent goes on the walk stack
                        r_node_vld[open_x] <= 1'b1;
                        r_cnt <= cnt1;
                        r_ns  <= r_ns + 1'b1;
                        r_wd  <= r_wd + 1'b1;
                        r_v   <= open_x;
                        r_e   <= head_val;
                        r_low <= cnt1;
                        r_vis <= cnt1;
                    end else if (!nd_done && nd_vis < r_low) begin
                        r_low <= nd_vis;
                    end
                end
                S_SCC_WR: begin
                    r_ns <= r_ns - 1'b1;
                end
                S_POP_LD: begin
                    r_wd  <= r_wd - 1'b1;
                    r_v   <= pop_node;
                    r_e   <= pop_edge;
                    r_vis <= pop_vis;
                    r_low <= (r_low < pop_low) ? r_low : pop_low;
                end
                S_CHK_B: begin
                    r_ca <= nd_comp;
                end
                S_CHK_C: begin
                    if (nd_comp == r_ca) begin
                        r_sat <= 1'b0;
                    end
                    r_i <= r_i + 1'b1;
                end
                S_DONE: begin
                    r_ovld     <= 1'b1;
                    r_osat     <= r_sat;
                    r_oerr     <= r_err;
                    r_err      <= 1'b0;
                    r_total    <= '0;
                    r_head_vld <= '0;
                    r_node_vld <= '0;
                    r_cnt      <= '0;
                    r_comp     <= '0;
                    r_ns       <= '0;
                    r_wd       <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // list heads per node
    tsc_ram #(.WIDTH(EW), .DEPTH(NODES)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );

    // edge store: link and destination
    tsc_ram #(.WIDTH(EDW), .DEPTH(EDGES)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    // per node visit number, done flag and component label
    tsc_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    // component node stack
    tsc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_nstack (
        .i_clk(i_clk), .i_we(ns_we), .i_waddr(ns_waddr), .i_wdata(ns_wdata),
        .i_raddr(ns_raddr), .o_rdata(ns_rdata)
    );

    // depth-first walk stack, entries below the cached top
    tsc_ram #(.WIDTH(WKW), .DEPTH(NODES)) u_walk (
        .i_clk(i_clk), .i_we(wk_we), .i_waddr(wk_waddr), .i_wdata(wk_wdata),
        .i_raddr(wk_raddr), .o_rdata(wk_rdata)
    );

`ifndef SYNTH
    // node stack never goes past the node count
    a_ns_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ns} <= NODES_L)
        else $error("node stack overflow");

    // every walk entry and the top are open nodes on the node stack
    a_walk_in_ns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> (r_wd < r_ns))
        else $error("walk stack deeper than node stack");

    // the edge store always has room for the last edge of a clause
    a_edge_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD2) |-> ({1'b0, r_total} < EDGES_L))
        else $error("edge store overrun");

    // a result appears only at the end of an evaluation
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_state == S_DONE))
        else $error("result without evaluation");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the 2-SAT component checker: directed clause sets and clause sets of random
// shape are loaded and evaluated, and each verdict is compared with a behavioral
// Tarjan search run on a local copy of the implication graph.
// ----------------------------------------------------------------------------
module testbench;
    import tsc_pkg::*;

    localparam int NV = DEF_MAX_VARS;
    localparam int NN = 2 * NV;
    localparam int NE = 2 * DEF_MAX_CLAUSES;

    typedef struct packed {
        logic       func;
        logic [7:0] var_a;
        logic       pol_a;
        logic [7:0] var_b;
        logic       pol_b;
    } t_item;

    typedef struct packed {
        logic sat;
        logic err;
    } t_verdict;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'd1;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_func = 1'b0;
    logic [7:0] i_var_a = 8'd0;
    logic       i_pol_a = 1'b0;
    logic [7:0] i_var_b = 8'd0;
    logic       i_pol_b = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_satisfiable;
    logic       o_clause_error;

    two_sat_scc_checker u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state: graph copy and search scratch
    int unsigned var_reg;
    int unsigned g_head[NN];
    int unsigned g_link[NE];
    int unsigned g_dest[NE];
    int unsigned g_total;
    bit          g_err;
    int unsigned t_vis[NN], t_low[NN], t_comp[NN];
    bit          t_done[NN];
    int unsigned t_nstk[NN], t_wnode[NN], t_wedge[NN];
    int unsigned t_vcnt, t_ccnt;

    t_item    pending_items[$];
    t_verdict expected_verdicts[$];
    int       errors = 0;

    task automatic report(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic int unsigned live_vars();
        if (var_reg == 0) return 1;
        if (var_reg > NV) return NV;
        return var_reg;
    endfunction

    function automatic void clear_graph();
        foreach (g_head[i]) begin
            g_head[i] = 0;
            t_vis[i]  = 0;
            t_done[i] = 1'b0;
        end
        g_total = 0;
        t_vcnt  = 0;
        t_ccnt  = 0;
        g_err   = 1'b0;
    endfunction

    function automatic void link_edge(input int unsigned from, input int unsigned to);
        g_link[g_total] = g_head[from];
        g_dest[g_total] = to;
        g_total++;
        g_head[from] = g_total;
    endfunction

    function automatic void open_node(input int unsigned v, inout int unsigned ns,
                                      inout int unsigned ws);
        t_vcnt++;
        t_vis[v] = t_vcnt;
        t_low[v] = t_vcnt;
        t_nstk[ns] = v;
        ns++;
        t_wnode[ws] = v;
        t_wedge[ws] = g_head[v];
        ws++;
    endfunction

    function automatic void tarjan_from(input int unsigned root);
        int unsigned ns, ws, v, e, w, x, p;
        ns = 0;
        ws = 0;
        open_node(root, ns, ws);
        while (ws > 0) begin
            v = t_wnode[ws-1];
            e = t_wedge[ws-1];
            if (e != 0 && e <= g_total) begin
                w = g_dest[e-1];
                t_wedge[ws-1] = g_link[e-1];
                if (w >= NN || t_done[w]) continue;
                if (t_vis[w] == 0) begin
                    if (ws < NN && ns < NN) open_node(w, ns, ws);
                    continue;
                end
                if (t_low[w] < t_low[v]) t_low[v] = t_low[w];
                continue;
            end
            ws--;
            if (t_low[v] == t_vis[v]) begin
                t_ccnt++;
                while (ns > 0) begin
                    x = t_nstk[ns-1];
                    ns--;
                    t_comp[x] = t_ccnt;
                    t_done[x] = 1'b1;
                    if (x == v) break;
                end
            end
            if (ws > 0) begin
                p = t_wnode[ws-1];
                if (t_low[v] < t_low[p]) t_low[p] = t_low[v];
            end
        end
    endfunction

    // apply one accepted item to the predictor
    function automatic void predict_item(input t_item it);
        int unsigned n;
        t_verdict vd;
        n = live_vars();
        if (it.func == FUNC_ADD) begin
            if (it.var_a == 0 || it.var_a > n || it.var_b == 0 || it.var_b > n
                    || g_total + 2 > NE) begin
                g_err = 1'b1;
            end else begin
                link_edge((it.pol_a ^ 1) * n + it.var_a - 1, it.pol_b * n + it.var_b - 1);
                link_edge((it.pol_b ^ 1) * n + it.var_b - 1, it.pol_a * n + it.var_a - 1);
            end
        end else begin
            for (int unsigned i = 0; i < 2 * n; i++)
                if (t_vis[i] == 0) tarjan_from(i);
            vd.sat = 1'b1;
            for (int unsigned i = 0; i < n; i++)
                if (t_comp[i] == t_comp[i+n]) begin
                    vd.sat = 1'b0;
                    break;
                end
            vd.err = g_err;
            expected_verdicts.push_back(vd);
            clear_graph();
        end
    endfunction

    function automatic t_item mk_item(input logic f, input int va, input logic pa,
                                      input int vb, input logic pb);
        t_item it;
        it.func = f;
        it.var_a = va[7:0];
        it.pol_a = pa;
        it.var_b = vb[7:0];
        it.pol_b = pb;
        return it;
    endfunction

    // random clause, mostly in range, sometimes out of it
    function automatic t_item rand_clause(input int n);
        int va, vb;
        va = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(1, n);
        vb = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(1, n);
        return mk_item(FUNC_ADD, va, 1'($urandom_range(0, 1)), vb,
                       1'($urandom_range(0, 1)));
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_verdicts.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic write_var_count(input int unsigned value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[7:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        var_reg = value[7:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // input transfer taken at the last rising edge
    bit in_taken = 1'b0;
    always @(posedge i_clk) begin
        in_taken <= i_valid && !o_stall;
    end

    // driver: bursts of transfers with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (gap_left > 0 || pending_items.size() == 0) begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    t_item it;
                    it = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_func  <= it.func;
                    i_var_a <= it.var_a;
                    i_pol_a <= it.pol_a;
                    i_var_b <= it.var_b;
                    i_pol_b <= it.pol_b;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver stall pattern
    int stall_mode = 0;
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // monitor: accepted inputs feed the predictor, results are compared
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                predict_item(mk_item(i_func, i_var_a, i_pol_a, i_var_b, i_pol_b));
            if (o_valid && !i_stall) begin
                if (expected_verdicts.size() == 0) begin
                    report("verdict with none expected");
                end else begin
                    t_verdict ev;
                    ev = expected_verdicts.pop_front();
                    if (o_satisfiable !== ev.sat)
                        report($sformatf("satisfiable %b expected %b", o_satisfiable, ev.sat));
                    if (o_clause_error !== ev.err)
                        report($sformatf("clause_error %b expected %b",
                                         o_clause_error, ev.err));
                end
            end
        end
    end

    // stimulus
    initial begin
        int n;
        var_reg = 1;
        clear_graph();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default count, then extremes and error cases
        pending_items.push_back(mk_item(FUNC_ADD, 1, 1, 1, 1));
        pending_items.push_back(mk_item(FUNC_EVAL, 255, 1, 255, 1));
        pending_items.push_back(mk_item(FUNC_ADD, 1, 1, 1, 1));
        pending_items.push_back(mk_item(FUNC_ADD, 1, 0, 1, 0));
        pending_items.push_back(mk_item(FUNC_EVAL, 0, 0, 0, 0));
        pending_items.push_back(mk_item(FUNC_ADD, 0, 0, 1, 1));
        pending_items.push_back(mk_item(FUNC_ADD, 1, 1, 2, 0));
        pending_items.push_back(mk_item(FUNC_EVAL, 0, 0, 0, 0));
        pending_items.push_back(mk_item(FUNC_EVAL, 0, 0, 0, 0));
        wait_drained();

        write_var_count(128);
        pending_items.push_back(mk_item(FUNC_ADD, 128, 1, 128, 0));
        pending_items.push_back(mk_item(FUNC_ADD, 129, 1, 1, 0));
        pending_items.push_back(mk_item(FUNC_ADD, 1, 0, 255, 1));
        pending_items.push_back(mk_item(FUNC_ADD, 85, 1, 170, 0));
        pending_items.push_back(mk_item(FUNC_EVAL, 0, 0, 0, 0));
        wait_drained();

        // zero acts as one variable, above max acts as max
        write_var_count(0);
        pending_items.push_back(mk_item(FUNC_ADD, 1, 1, 1, 1));
        pending_items.push_back(mk_item(FUNC_ADD, 2, 1, 1, 1));
        pending_items.push_back(mk_item(FUNC_EVAL, 0, 0, 0, 0));
        wait_drained();
        write_var_count(255);
        pending_items.push_back(mk_item(FUNC_ADD, 128, 0, 64, 1));
        pending_items.push_back(mk_item(FUNC_EVAL, 0, 0, 0, 0));
        wait_drained();

        // edge store overflow: more clauses than fit, then evaluate
        write_var_count(3);
        for (int i = 0; i < DEF_MAX_CLAUSES + 4; i++)
            pending_items.push_back(mk_item(FUNC_ADD, $urandom_range(1, 3),
                1'($urandom_range(0, 1)), $urandom_range(1, 3),
                1'($urandom_range(0, 1))));
        pending_items.push_back(mk_item(FUNC_EVAL, 0, 0, 0, 0));
        wait_drained();

        // random formulas; count set per phase, and once changed between clauses
        for (int phase = 0; phase < 14; phase++) begin
            case (phase % 4)
                0: n = $urandom_range(1, 4);
                1: n = $urandom_range(2, 16);
                2: n = $urandom_range(1, 255);
                default: n = 128;
            endcase
            write_var_count(n);
            n = live_vars();
            for (int f = 0; f < 2; f++) begin
                int clauses;
                clauses = $urandom_range(0, 2 * n + 3);
                if (clauses > 20) clauses = $urandom_range(0, 20);
                for (int c = 0; c < clauses; c++)
                    pending_items.push_back(rand_clause(n));
                pending_items.push_back(mk_item(FUNC_EVAL, $urandom_range(0, 255),
                    1'($urandom_range(0, 1)), $urandom_range(0, 255),
                    1'($urandom_range(0, 1))));
            end
            wait_drained();
            if (phase == 6) begin
                // register changed between clauses of one formula
                write_var_count(4);
                pending_items.push_back(mk_item(FUNC_ADD, 4, 1, 2, 0));
                pending_items.push_back(mk_item(FUNC_ADD, 3, 0, 1, 1));
                wait_drained();
                write_var_count(2);
                pending_items.push_back(mk_item(FUNC_ADD, 1, 0, 2, 1));
                pending_items.push_back(mk_item(FUNC_EVAL, 0, 0, 0, 0));
                wait_drained();
            end
        end

        if (errors == 0 && expected_verdicts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

endmodule
